### rtl/core/ict_pkg.sv
// Package: types, constants and control-code decode for the interrupt channel control table.
package ict_pkg;

  localparam int CHANNEL_COUNT_DEF = 768;
  localparam int CH_W              = 10;
  localparam int KIND_W            = 2;
  localparam int CODE_W            = 3;
  localparam int ENTRY_W           = 2;

  // entry layout: bit 1 request flag, bit 0 mask
  localparam int FLAG_BIT = 1;
  localparam int MASK_BIT = 0;
  localparam logic [ENTRY_W-1:0] ENTRY_RESET = 2'b01;

  typedef enum logic [KIND_W-1:0] {
    KIND_CTRL   = 2'd0,
    KIND_RDFLAG = 2'd1,
    KIND_RDENA  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ACT_DISABLE = 3'd0,
    ACT_ENABLE  = 3'd1,
    ACT_CLR_DIS = 3'd2,
    ACT_CLR_ENA = 3'd3,
    ACT_SET_ENA = 3'd4
  } act_t;

  function automatic act_t action_of_code(input logic [CODE_W-1:0] code);
    act_t act;
    case (code)
      3'd1, 3'd7: act = ACT_ENABLE;
      3'd2:       act = ACT_CLR_DIS;
      3'd3:       act = ACT_CLR_ENA;
      3'd5:       act = ACT_SET_ENA;
      default:    act = ACT_DISABLE;
    endcase
    return act;
  endfunction

  function automatic logic [ENTRY_W-1:0] apply_control(input logic [CODE_W-1:0]  code,
                                                       input logic [ENTRY_W-1:0] old);
    logic [ENTRY_W-1:0] res;
    res = old;
    case (action_of_code(code))
      ACT_DISABLE: res[MASK_BIT] = 1'b1;
      ACT_ENABLE:  res[MASK_BIT] = 1'b0;
      ACT_CLR_DIS: res = 2'b01;
      ACT_CLR_ENA: res = 2'b00;
      ACT_SET_ENA: res = 2'b10;
      default:     res = old;
    endcase
    return res;
  endfunction

endpackage

### rtl/core/ict_if.sv
// Interfaces: request and result channels of the interrupt channel control table.
interface ict_in_if;
  logic                       valid;
  logic                       ready;
  logic [ict_pkg::KIND_W-1:0] kind;
  logic [ict_pkg::CH_W-1:0]   channel;
  logic [ict_pkg::CODE_W-1:0] control_code;
  logic                       clear_after_read;

  modport source (output valid, kind, channel, control_code, clear_after_read, input ready);
  modport sink   (input valid, kind, channel, control_code, clear_after_read, output ready);
endinterface

interface ict_out_if;
  logic valid;
  logic ready;
  logic channel_ok;
  logic request_flag;
  logic enabled;

  modport source (output valid, channel_ok, request_flag, enabled, input ready);
  modport sink   (input valid, channel_ok, request_flag, enabled, output ready);
endinterface

### rtl/core/interrupt_channel_control_table_top.sv
// Top level: interrupt channel control table (mask bit and request flag per channel).
//
// Usage:
//   in_ch  carries one operation per beat: kind (control update, request-flag
//          read, enabled read), channel, control_code and clear_after_read.
//   out_ch returns one beat per operation: channel_ok and the channel's
//          request flag and enabled state as they stood before the operation.
//   An accepted beat is read from the table, modified and written back
//   from the read stage, and shown on out_ch from the output register.
//   Throughput is one beat per cycle unless out_ch stalls; a one-entry write
//   forward covers a read of the entry written in the cycle before.
//   After reset the table is swept once, one entry per cycle, setting every
//   flag to zero and every mask to one; in_ch.ready stays low during
//   the sweep.
//   When out_ch stalls, one beat waits in the output register and one in the
//   read stage; in_ch.ready drops until the output register frees.
module interrupt_channel_control_table_top #(
  parameter int CHANNEL_COUNT = ict_pkg::CHANNEL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ict_in_if.sink            in_ch,
  ict_out_if.source         out_ch
);

  localparam int AW = $clog2(CHANNEL_COUNT);

  // reset sweep
  logic          clearing_r, clearing_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // read stage
  logic                             s1_valid_r;
  logic                             s1_ok_r;
  logic [AW-1:0]                    s1_addr_r;
  logic [ict_pkg::KIND_W-1:0]       s1_kind_r;
  logic [ict_pkg::CODE_W-1:0]       s1_code_r;
  logic                             s1_clr_r;

  // last item write, for forwarding
  logic                             lw_valid_r;
  logic [AW-1:0]                    lw_addr_r;
  logic [ict_pkg::ENTRY_W-1:0]      lw_data_r;

  // output register
  logic out_valid_r, out_ok_r, out_flag_r, out_ena_r;

  logic                        accept, s1_adv, in_ok;
  logic                        item_we, ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ict_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata, old_entry, new_entry;

  assign in_ok  = {1'b0, in_ch.channel} < (ict_pkg::CH_W + 1)'(CHANNEL_COUNT);
  assign s1_adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign accept = in_ch.valid && in_ch.ready;

  assign old_entry = (lw_valid_r && lw_addr_r == s1_addr_r) ? lw_data_r : ram_rdata;

  always_comb begin
    new_entry = old_entry;
    item_we   = 1'b0;
    case (s1_kind_r)
      ict_pkg::KIND_CTRL: begin
        new_entry = ict_pkg::apply_control(s1_code_r, old_entry);
        item_we   = 1'b1;
      end
      ict_pkg::KIND_RDFLAG: begin
        new_entry[ict_pkg::FLAG_BIT] = old_entry[ict_pkg::FLAG_BIT] & ~s1_clr_r;
        item_we   = 1'b1;
      end
      default: begin
        new_entry = old_entry;
        item_we   = 1'b0;
      end
    endcase
    item_we = item_we && s1_valid_r && s1_adv && s1_ok_r;
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(CHANNEL_COUNT - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  assign ram_we    = clearing_r || item_we;
  assign ram_waddr = clearing_r ? clr_cnt_r : s1_addr_r;
  assign ram_wdata = clearing_r ? ict_pkg::ENTRY_RESET : new_entry;

  ict_ram #(
    .WIDTH (ict_pkg::ENTRY_W),
    .DEPTH (CHANNEL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_ch.channel[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (item_we) begin
        lw_valid_r <= 1'b1;
      end
      if (s1_valid_r && s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r   <= in_ok;
      s1_addr_r <= in_ch.channel[AW-1:0];
      s1_kind_r <= in_ch.kind;
      s1_code_r <= in_ch.control_code;
      s1_clr_r  <= in_ch.clear_after_read;
    end
    if (item_we) begin
      lw_addr_r <= s1_addr_r;
      lw_data_r <= new_entry;
    end
    if (s1_valid_r && s1_adv) begin
      out_ok_r   <= s1_ok_r;
      out_flag_r <= s1_ok_r & old_entry[ict_pkg::FLAG_BIT];
      out_ena_r  <= s1_ok_r & ~old_entry[ict_pkg::MASK_BIT];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.channel_ok   = out_ok_r;
  assign out_ch.request_flag = out_flag_r;
  assign out_ch.enabled      = out_ena_r;

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ch.ready)
    else $error("beat accepted during reset sweep");

  a_no_item_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !item_we)
    else $error("item write during reset sweep");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted beat lost before read stage");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (!out_flag_r && !out_ena_r))
    else $error("invalid channel reports nonzero status");

endmodule

### rtl/core/ict_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ict_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
